### hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// property that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`endif

### hw/rtl/c8cpu_pkg.sv
// types, constants and helper functions of the chip-8 processor
// no dependencies
package c8cpu_pkg;

  localparam int unsigned FontBytes = 80;
  localparam int unsigned Rows      = 32;
  localparam logic [11:0] StartPc   = 12'h200;

  localparam logic [1:0] FuncExec  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncRow   = 2'd2;

  localparam logic [3:0] NibSys  = 4'h0;
  localparam logic [3:0] NibJp   = 4'h1;
  localparam logic [3:0] NibCall = 4'h2;
  localparam logic [3:0] NibSeq  = 4'h3;
  localparam logic [3:0] NibSne  = 4'h4;
  localparam logic [3:0] NibSeqr = 4'h5;
  localparam logic [3:0] NibLd   = 4'h6;
  localparam logic [3:0] NibAdd  = 4'h7;
  localparam logic [3:0] NibAlu  = 4'h8;
  localparam logic [3:0] NibSner = 4'h9;
  localparam logic [3:0] NibLdi  = 4'hA;
  localparam logic [3:0] NibJpv  = 4'hB;
  localparam logic [3:0] NibRnd  = 4'hC;
  localparam logic [3:0] NibDrw  = 4'hD;
  localparam logic [3:0] NibKey  = 4'hE;
  localparam logic [3:0] NibMisc = 4'hF;

  localparam logic [15:0] OpCls = 16'h00E0;
  localparam logic [15:0] OpRet = 16'h00EE;

  localparam logic [3:0] AluMov  = 4'h0;
  localparam logic [3:0] AluOr   = 4'h1;
  localparam logic [3:0] AluAnd  = 4'h2;
  localparam logic [3:0] AluXor  = 4'h3;
  localparam logic [3:0] AluAdd  = 4'h4;
  localparam logic [3:0] AluSub  = 4'h5;
  localparam logic [3:0] AluShr  = 4'h6;
  localparam logic [3:0] AluSubn = 4'h7;
  localparam logic [3:0] AluShl  = 4'hE;

  localparam logic [7:0] KeySkp  = 8'h9E;
  localparam logic [7:0] KeySknp = 8'hA1;

  localparam logic [7:0] FnGetDt   = 8'h07;
  localparam logic [7:0] FnWaitKey = 8'h0A;
  localparam logic [7:0] FnSetDt   = 8'h15;
  localparam logic [7:0] FnSetSt   = 8'h18;
  localparam logic [7:0] FnAddI    = 8'h1E;
  localparam logic [7:0] FnFont    = 8'h29;
  localparam logic [7:0] FnBcd     = 8'h33;
  localparam logic [7:0] FnDump    = 8'h55;
  localparam logic [7:0] FnLoad    = 8'h65;

  localparam logic [7:0] FONT [0:79] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    UOP_NONE, UOP_CLEAR, UOP_ACCEPT, UOP_DISPATCH, UOP_FETCH0, UOP_FETCH1,
    UOP_FETCH2, UOP_RDX, UOP_RDY, UOP_RD0, UOP_EXEC, UOP_WRVF, UOP_DRAW_RD,
    UOP_DRAW_XOR, UOP_DRAW_VF, UOP_BCD, UOP_DUMP_RD, UOP_DUMP_WR, UOP_LOAD_RD,
    UOP_LOAD_WR, UOP_TICK, UOP_RESULT
  } uop_e;

  typedef struct packed {
    uop_e        uop;
    logic        fire;
    logic [11:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] opcode;
  } stat_t;

  // binary to three bcd digits, shift and add-three
  function automatic logic [11:0] bin_to_bcd(input logic [7:0] v);
    logic [19:0] s;
    s = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] > 4'd4) s[11:8] = s[11:8] + 4'd3;
      if (s[15:12] > 4'd4) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] > 4'd4) s[19:16] = s[19:16] + 4'd3;
      s = {s[18:0], 1'b0};
    end
    return s[19:8];
  endfunction

  // highest held key
  function automatic logic [3:0] top_key(input logic [15:0] k);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (k[i]) r = 4'(i);
    end
    return r;
  endfunction

endpackage

### hw/rtl/c8cpu_in_if.sv
// input channel of the chip-8 processor
// depends on nothing
interface c8cpu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] mem_addr;
  logic [7:0]  mem_data;
  logic [15:0] keys;
  logic [7:0]  rand_value;

  modport source (output valid, func, mem_addr, mem_data, keys, rand_value, input ready);
  modport sink (input valid, func, mem_addr, mem_data, keys, rand_value, output ready);
endinterface

### hw/rtl/c8cpu_out_if.sv
// result channel of the chip-8 processor
// depends on nothing
interface c8cpu_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pc;
  logic [15:0] opcode;
  logic        redraw;
  logic        beep;
  logic        key_wait;
  logic [63:0] display_row;

  modport source (output valid, pc, opcode, redraw, beep, key_wait, display_row,
                  input ready);
  modport sink (input valid, pc, opcode, redraw, beep, key_wait, display_row,
                output ready);
endinterface

### hw/rtl/c8cpu_ram.sv
// generic single-write single-read ram with registered read
// no dependencies
module c8cpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hw/rtl/c8cpu_ctrl.sv
// sequencer of the chip-8 processor: clearing pass, fetch, execute, loops
// depends on c8cpu_pkg
module c8cpu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  c8cpu_pkg::stat_t  stat_i,
  output c8cpu_pkg::cmd_t   cmd_o
);
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISP, ST_F0, ST_F1, ST_F2, ST_RX, ST_RY, ST_R0,
    ST_EXEC, ST_VF, ST_DRD, ST_DXOR, ST_DVF, ST_BCD, ST_DMPR, ST_DMPW,
    ST_LDR, ST_LDW, ST_TICK, ST_DONE
  } state_e;

  state_e      state_q, state_d;
  logic [11:0] cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [3:0]  nib, n, x;
  logic [7:0]  nn;
  logic        is_flag, slot_free, fire;

  assign nib = stat_i.opcode[15:12];
  assign x   = stat_i.opcode[11:8];
  assign n   = stat_i.opcode[3:0];
  assign nn  = stat_i.opcode[7:0];
  assign is_flag = (nib == c8cpu_pkg::NibAlu) &&
                   (n == c8cpu_pkg::AluAdd || n == c8cpu_pkg::AluSub ||
                    n == c8cpu_pkg::AluShr || n == c8cpu_pkg::AluSubn ||
                    n == c8cpu_pkg::AluShl);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.uop   = c8cpu_pkg::UOP_NONE;
    cmd_o.fire  = fire;
    cmd_o.cnt   = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.uop = c8cpu_pkg::UOP_CLEAR;
        cnt_d = cnt_q + 12'd1;
        if (cnt_q == 12'hFFF) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.uop = c8cpu_pkg::UOP_ACCEPT;
        if (fire) state_d = ST_DISP;
      end
      ST_DISP: begin
        cmd_o.uop = c8cpu_pkg::UOP_DISPATCH;
        state_d = (stat_i.func == c8cpu_pkg::FuncExec) ? ST_F0 : ST_DONE;
      end
      ST_F0: begin
        cmd_o.uop = c8cpu_pkg::UOP_FETCH0;
        state_d = ST_F1;
      end
      ST_F1: begin
        cmd_o.uop = c8cpu_pkg::UOP_FETCH1;
        state_d = ST_F2;
      end
      ST_F2: begin
        cmd_o.uop = c8cpu_pkg::UOP_FETCH2;
        state_d = ST_RX;
      end
      ST_RX: begin
        cmd_o.uop = c8cpu_pkg::UOP_RDX;
        state_d = ST_RY;
      end
      ST_RY: begin
        cmd_o.uop = c8cpu_pkg::UOP_RDY;
        state_d = ST_R0;
      end
      ST_R0: begin
        cmd_o.uop = c8cpu_pkg::UOP_RD0;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.uop = c8cpu_pkg::UOP_EXEC;
        cnt_d = 12'd0;
        state_d = ST_TICK;
        if (nib == c8cpu_pkg::NibDrw) begin
          state_d = (n == 4'd0) ? ST_DVF : ST_DRD;
        end else if (is_flag) begin
          state_d = ST_VF;
        end else if (nib == c8cpu_pkg::NibMisc) begin
          if (nn == c8cpu_pkg::FnBcd) state_d = ST_BCD;
          else if (nn == c8cpu_pkg::FnDump) state_d = ST_DMPR;
          else if (nn == c8cpu_pkg::FnLoad) state_d = ST_LDR;
        end
      end
      ST_VF: begin
        cmd_o.uop = c8cpu_pkg::UOP_WRVF;
        state_d = ST_TICK;
      end
      ST_DRD: begin
        cmd_o.uop = c8cpu_pkg::UOP_DRAW_RD;
        state_d = ST_DXOR;
      end
      ST_DXOR: begin
        cmd_o.uop = c8cpu_pkg::UOP_DRAW_XOR;
        cnt_d = cnt_q + 12'd1;
        state_d = (cnt_q[3:0] == n - 4'd1) ? ST_DVF : ST_DRD;
      end
      ST_DVF: begin
        cmd_o.uop = c8cpu_pkg::UOP_DRAW_VF;
        state_d = ST_TICK;
      end
      ST_BCD: begin
        cmd_o.uop = c8cpu_pkg::UOP_BCD;
        cnt_d = cnt_q + 12'd1;
        if (cnt_q[1:0] == 2'd2) state_d = ST_TICK;
      end
      ST_DMPR: begin
        cmd_o.uop = c8cpu_pkg::UOP_DUMP_RD;
        state_d = ST_DMPW;
      end
      ST_DMPW: begin
        cmd_o.uop = c8cpu_pkg::UOP_DUMP_WR;
        cnt_d = cnt_q + 12'd1;
        state_d = (cnt_q[3:0] == x) ? ST_TICK : ST_DMPR;
      end
      ST_LDR: begin
        cmd_o.uop = c8cpu_pkg::UOP_LOAD_RD;
        state_d = ST_LDW;
      end
      ST_LDW: begin
        cmd_o.uop = c8cpu_pkg::UOP_LOAD_WR;
        cnt_d = cnt_q + 12'd1;
        state_d = (cnt_q[3:0] == x) ? ST_TICK : ST_LDR;
      end
      ST_TICK: begin
        cmd_o.uop = c8cpu_pkg::UOP_TICK;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.uop   = c8cpu_pkg::UOP_RESULT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= 12'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

### hw/rtl/c8cpu_dpath.sv
// datapath of the chip-8 processor: memories, registers, frame, result register
// depends on c8cpu_pkg and c8cpu_ram
module c8cpu_dpath #(
  parameter int unsigned STACK_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  c8cpu_pkg::cmd_t  cmd_i,
  output c8cpu_pkg::stat_t stat_o,
  input  logic [1:0]       func_i,
  input  logic [11:0]      mem_addr_i,
  input  logic [7:0]       mem_data_i,
  input  logic [15:0]      keys_i,
  input  logic [7:0]       rand_value_i,
  output logic [11:0]      pc_o,
  output logic [15:0]      opcode_o,
  output logic             redraw_o,
  output logic             beep_o,
  output logic             key_wait_o,
  output logic [63:0]      display_row_o
);
  localparam int unsigned SW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int unsigned DW = $clog2(STACK_ENTRIES + 1);

  logic [1:0]  func_q;
  logic [11:0] addr_q;
  logic [7:0]  data_q, rnd_q;
  logic [15:0] keys_q;
  logic [15:0] op_q, op_d;
  logic [7:0]  vx_q, vx_d, vy_q, vy_d;
  logic [11:0] pc_q, pc_d, i_q, i_d;
  logic [DW-1:0] depth_q, depth_d, depth_m1;
  logic [11:0] stack_q [STACK_ENTRIES];
  logic        push;
  logic [7:0]  dt_q, dt_d, st_q, st_d;
  logic        hit_q, hit_d, flag_q, flag_d;
  logic        redraw_q, redraw_d, beep_q, beep_d, wait_q, wait_d;
  logic [63:0] row_q, row_d;
  logic [63:0] frame_q [32];
  logic        frame_clr, frame_xor;

  logic        m_we;
  logic [11:0] m_waddr, m_raddr;
  logic [7:0]  m_wdata, m_rdata;
  logic        v_we;
  logic [3:0]  v_waddr, v_raddr;
  logic [7:0]  v_wdata, v_rdata;

  logic [3:0]   x, y, n;
  logic [7:0]   nn;
  logic [11:0]  nnn, pc2, pc4, spr_addr;
  logic [4:0]   row_sel;
  logic [127:0] rot;
  logic [63:0]  mask;
  logic [8:0]   sum9;
  logic [11:0]  bcd;
  logic         key_x;

  assign x   = op_q[11:8];
  assign y   = op_q[7:4];
  assign n   = op_q[3:0];
  assign nn  = op_q[7:0];
  assign nnn = op_q[11:0];
  assign pc2 = pc_q + 12'd2;
  assign pc4 = pc_q + 12'd4;
  assign spr_addr = i_q + cmd_i.cnt;
  assign row_sel  = vy_q[4:0] + cmd_i.cnt[4:0];
  assign rot  = {m_rdata, 56'd0, m_rdata, 56'd0} >> vx_q[5:0];
  assign mask = rot[63:0];
  assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};
  assign bcd  = c8cpu_pkg::bin_to_bcd(vx_q);
  assign key_x = keys_q[vx_q[3:0]];
  assign depth_m1 = depth_q - DW'(1);

  assign stat_o.func   = func_q;
  assign stat_o.opcode = op_q;

  c8cpu_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  c8cpu_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  always_comb begin
    op_d = op_q;   vx_d = vx_q;     vy_d = vy_q;
    pc_d = pc_q;   i_d = i_q;       depth_d = depth_q;  push = 1'b0;
    dt_d = dt_q;   st_d = st_q;     hit_d = hit_q;      flag_d = flag_q;
    redraw_d = redraw_q; beep_d = beep_q; wait_d = wait_q; row_d = row_q;
    frame_clr = 1'b0; frame_xor = 1'b0;
    m_we = 1'b0; m_waddr = spr_addr; m_wdata = 8'd0; m_raddr = 12'd0;
    v_we = 1'b0; v_waddr = x;        v_wdata = 8'd0; v_raddr = 4'd0;
    case (cmd_i.uop)
      c8cpu_pkg::UOP_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = cmd_i.cnt;
        m_wdata = (cmd_i.cnt < 12'(c8cpu_pkg::FontBytes)) ?
                  c8cpu_pkg::FONT[cmd_i.cnt[6:0]] : 8'd0;
        v_we    = (cmd_i.cnt < 12'd16);
        v_waddr = cmd_i.cnt[3:0];
      end
      c8cpu_pkg::UOP_DISPATCH: begin
        redraw_d = 1'b0; beep_d = 1'b0; wait_d = 1'b0;
        row_d    = (addr_q < 12'(c8cpu_pkg::Rows)) ? frame_q[addr_q[4:0]] : 64'd0;
        if (func_q == c8cpu_pkg::FuncWrite) begin
          m_we = 1'b1; m_waddr = addr_q; m_wdata = data_q;
        end
      end
      c8cpu_pkg::UOP_FETCH0: m_raddr = pc_q;
      c8cpu_pkg::UOP_FETCH1: begin
        op_d[15:8] = m_rdata;
        m_raddr    = pc_q + 12'd1;
      end
      c8cpu_pkg::UOP_FETCH2: op_d[7:0] = m_rdata;
      c8cpu_pkg::UOP_RDX: v_raddr = x;
      c8cpu_pkg::UOP_RDY: begin
        vx_d = v_rdata; v_raddr = y;
      end
      c8cpu_pkg::UOP_RD0: begin
        vy_d = v_rdata; v_raddr = 4'd0;
      end
      c8cpu_pkg::UOP_EXEC: begin
        pc_d  = pc2;
        hit_d = 1'b0;
        case (op_q[15:12])
          c8cpu_pkg::NibSys: begin
            if (op_q == c8cpu_pkg::OpCls) begin
              frame_clr = 1'b1; redraw_d = 1'b1;
            end else if (op_q == c8cpu_pkg::OpRet && depth_q != '0) begin
              depth_d = depth_m1;
              pc_d    = stack_q[depth_m1[SW-1:0]] + 12'd2;
            end
          end
          c8cpu_pkg::NibJp: pc_d = nnn;
          c8cpu_pkg::NibCall: begin
            if (depth_q < DW'(STACK_ENTRIES)) begin
              push = 1'b1; depth_d = depth_q + DW'(1);
            end
            pc_d = nnn;
          end
          c8cpu_pkg::NibSeq:  if (vx_q == nn) pc_d = pc4;
          c8cpu_pkg::NibSne:  if (vx_q != nn) pc_d = pc4;
          c8cpu_pkg::NibSeqr: if (vx_q == vy_q) pc_d = pc4;
          c8cpu_pkg::NibSner: if (vx_q != vy_q) pc_d = pc4;
          c8cpu_pkg::NibLd: begin
            v_we = 1'b1; v_wdata = nn;
          end
          c8cpu_pkg::NibAdd: begin
            v_we = 1'b1; v_wdata = vx_q + nn;
          end
          c8cpu_pkg::NibAlu: begin
            case (n)
              c8cpu_pkg::AluMov: begin v_we = 1'b1; v_wdata = vy_q; end
              c8cpu_pkg::AluOr:  begin v_we = 1'b1; v_wdata = vx_q | vy_q; end
              c8cpu_pkg::AluAnd: begin v_we = 1'b1; v_wdata = vx_q & vy_q; end
              c8cpu_pkg::AluXor: begin v_we = 1'b1; v_wdata = vx_q ^ vy_q; end
              c8cpu_pkg::AluAdd: begin
                v_we = 1'b1; v_wdata = sum9[7:0]; flag_d = sum9[8];
              end
              c8cpu_pkg::AluSub: begin
                v_we = 1'b1; v_wdata = vx_q - vy_q; flag_d = (vx_q >= vy_q);
              end
              c8cpu_pkg::AluShr: begin
                v_we = 1'b1; v_wdata = {1'b0, vx_q[7:1]}; flag_d = vx_q[0];
              end
              c8cpu_pkg::AluSubn: begin
                v_we = 1'b1; v_wdata = vy_q - vx_q; flag_d = (vy_q >= vx_q);
              end
              c8cpu_pkg::AluShl: begin
                v_we = 1'b1; v_wdata = {vx_q[6:0], 1'b0}; flag_d = vx_q[7];
              end
              default: ;
            endcase
          end
          c8cpu_pkg::NibLdi: i_d = nnn;
          c8cpu_pkg::NibJpv: pc_d = nnn + {4'd0, v_rdata};
          c8cpu_pkg::NibRnd: begin
            v_we = 1'b1; v_wdata = rnd_q & nn;
          end
          c8cpu_pkg::NibDrw: redraw_d = 1'b1;
          c8cpu_pkg::NibKey: begin
            if (nn == c8cpu_pkg::KeySkp && key_x) pc_d = pc4;
            else if (nn == c8cpu_pkg::KeySknp && !key_x) pc_d = pc4;
          end
          c8cpu_pkg::NibMisc: begin
            case (nn)
              c8cpu_pkg::FnGetDt: begin v_we = 1'b1; v_wdata = dt_q; end
              c8cpu_pkg::FnWaitKey: begin
                if (keys_q == 16'd0) begin
                  wait_d = 1'b1; pc_d = pc_q;
                end else begin
                  v_we = 1'b1; v_wdata = {4'd0, c8cpu_pkg::top_key(keys_q)};
                end
              end
              c8cpu_pkg::FnSetDt: dt_d = vx_q;
              c8cpu_pkg::FnSetSt: st_d = vx_q;
              c8cpu_pkg::FnAddI:  i_d = i_q + {4'd0, vx_q};
              c8cpu_pkg::FnFont:
                i_d = {6'd0, vx_q[3:0], 2'b00} + {8'd0, vx_q[3:0]};
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      c8cpu_pkg::UOP_WRVF: begin
        v_we = 1'b1; v_waddr = 4'hF; v_wdata = {7'd0, flag_q};
      end
      c8cpu_pkg::UOP_DRAW_RD: m_raddr = spr_addr;
      c8cpu_pkg::UOP_DRAW_XOR: begin
        frame_xor = 1'b1;
        hit_d     = hit_q | (|(frame_q[row_sel] & mask));
      end
      c8cpu_pkg::UOP_DRAW_VF: begin
        v_we = 1'b1; v_waddr = 4'hF; v_wdata = {7'd0, hit_q};
      end
      c8cpu_pkg::UOP_BCD: begin
        m_we = 1'b1;
        case (cmd_i.cnt[1:0])
          2'd0:    m_wdata = {4'd0, bcd[11:8]};
          2'd1:    m_wdata = {4'd0, bcd[7:4]};
          default: m_wdata = {4'd0, bcd[3:0]};
        endcase
      end
      c8cpu_pkg::UOP_DUMP_RD: v_raddr = cmd_i.cnt[3:0];
      c8cpu_pkg::UOP_DUMP_WR: begin
        m_we = 1'b1; m_wdata = v_rdata;
      end
      c8cpu_pkg::UOP_LOAD_RD: m_raddr = spr_addr;
      c8cpu_pkg::UOP_LOAD_WR: begin
        v_we = 1'b1; v_waddr = cmd_i.cnt[3:0]; v_wdata = m_rdata;
      end
      c8cpu_pkg::UOP_TICK: begin
        if (dt_q != 8'd0) dt_d = dt_q - 8'd1;
        if (st_q != 8'd0) st_d = st_q - 8'd1;
        beep_d = (st_q == 8'd1);
      end
      default: ;
    endcase
  end

  // accepted item, stack push and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.uop == c8cpu_pkg::UOP_ACCEPT && cmd_i.fire) begin
      func_q <= func_i;
      addr_q <= mem_addr_i;
      data_q <= mem_data_i;
      keys_q <= keys_i;
      rnd_q  <= rand_value_i;
    end
    if (push) stack_q[depth_q[SW-1:0]] <= pc_q;
    if (cmd_i.uop == c8cpu_pkg::UOP_RESULT) begin
      pc_o          <= pc_q;
      opcode_o      <= (func_q == c8cpu_pkg::FuncExec) ? op_q : 16'd0;
      redraw_o      <= redraw_q;
      beep_o        <= beep_q;
      key_wait_o    <= wait_q;
      display_row_o <= (func_q == c8cpu_pkg::FuncRow) ? row_q : 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= 16'd0; vx_q <= 8'd0; vy_q <= 8'd0;
      pc_q <= c8cpu_pkg::StartPc; i_q <= 12'd0; depth_q <= '0;
      dt_q <= 8'd0; st_q <= 8'd0; hit_q <= 1'b0; flag_q <= 1'b0;
      redraw_q <= 1'b0; beep_q <= 1'b0; wait_q <= 1'b0; row_q <= 64'd0;
      frame_q <= '{default: 64'd0};
    end else begin
      op_q <= op_d; vx_q <= vx_d; vy_q <= vy_d;
      pc_q <= pc_d; i_q <= i_d; depth_q <= depth_d;
      dt_q <= dt_d; st_q <= st_d; hit_q <= hit_d; flag_q <= flag_d;
      redraw_q <= redraw_d; beep_q <= beep_d; wait_q <= wait_d; row_q <= row_d;
      if (frame_clr) frame_q <= '{default: 64'd0};
      else if (frame_xor) frame_q[row_sel] <= frame_q[row_sel] ^ mask;
    end
  end
endmodule

### hw/rtl/chip8_cpu_core_unit.sv
// chip-8 processor top level: sequencer, datapath and channel wiring
// depends on c8cpu_pkg, c8cpu_in_if, c8cpu_out_if, c8cpu_ctrl, c8cpu_dpath
// After reset the block loads the font into the 4 KiB program memory and
// clears the rest, and takes no transaction meanwhile. Then it handles one
// transaction at a time. A memory write, a row read or an unused func goes
// from acceptance to result; an instruction is fetched, reads its registers
// and executes, plus a step for flag-setting arithmetic, a read and an xor
// per sprite row and a flag step for DXYN, a write per digit for FX33 and a
// read and a write per register for FX55/FX65. This follows from the single
// read port of the program memory and of the register file, which the
// sequencer walks one access per cycle. A finished result sits in an output
// register, so a new transaction is taken while it waits.
`include "assert_macros.svh"

module chip8_cpu_core_unit #(
  parameter int unsigned STACK_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  c8cpu_in_if.sink    in_i,
  c8cpu_out_if.source out_o
);
  c8cpu_pkg::cmd_t  cmd;
  c8cpu_pkg::stat_t stat;

  c8cpu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  c8cpu_dpath #(.STACK_ENTRIES(STACK_ENTRIES)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .func_i(in_i.func), .mem_addr_i(in_i.mem_addr), .mem_data_i(in_i.mem_data),
    .keys_i(in_i.keys), .rand_value_i(in_i.rand_value),
    .pc_o(out_o.pc), .opcode_o(out_o.opcode), .redraw_o(out_o.redraw),
    .beep_o(out_o.beep), .key_wait_o(out_o.key_wait),
    .display_row_o(out_o.display_row)
  );

  `ASSERT_NEVER(a_no_accept_in_clear, clk_i, rst_ni, cmd.uop == c8cpu_pkg::UOP_CLEAR && in_i.ready)
  `ASSERT_CLK(a_one_at_a_time, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> !in_i.ready)
  `ASSERT_CLK(a_slot_free_on_load, clk_i, rst_ni, cmd.uop == c8cpu_pkg::UOP_RESULT |-> (!out_o.valid || out_o.ready))
  `ASSERT_CLK(a_valid_after_load, clk_i, rst_ni, cmd.uop == c8cpu_pkg::UOP_RESULT |=> out_o.valid)
endmodule
